// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; they expand to nothing when SYNTH is defined.
// Both macros expect signals named clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEVER(label, cond)
`endif

`endif

// ----- hw/rtl/kvsa_pkg.sv -----
// ----------------------------------------------------------------------------
// kvsa_pkg
// Types and constants of the keyed sample variance aggregator.
// ----------------------------------------------------------------------------
package kvsa_pkg;

	// one input row
	typedef struct packed {
		logic               mode;
		logic [63:0]        sample;
		logic               sample_is_null;
		logic signed [31:0] row_key;
	} in_item_t;

	// one variance result
	typedef struct packed {
		logic [1:0]  bucket;
		logic [63:0] variance;
		logic        variance_is_null;
		logic        last;
	} out_item_t;

	// operations of the shared floating-point unit
	typedef enum logic [2:0] {
		FOP_ADD,
		FOP_SUB,
		FOP_MUL,
		FOP_DIV,
		FOP_CVT
	} fpu_op_t;

	// request into the floating-point unit
	typedef struct packed {
		logic        start;
		fpu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	// status and result from the floating-point unit
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;
	} fpu_rsp_t;

	// aggregator sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC_SQ,
		ST_ACC_SS,
		ST_ACC_RS,
		ST_FIN_CHECK,
		ST_FIN_CVT_N,
		ST_FIN_PROD,
		ST_FIN_QUOT,
		ST_FIN_NUM,
		ST_FIN_CVT_M,
		ST_FIN_VAR,
		ST_FIN_EMIT
	} agg_state_t;

	// floating-point unit sequencer
	typedef enum logic [3:0] {
		FS_IDLE,
		FS_PRENORM,
		FS_MUL,
		FS_DIV,
		FS_ALIGN,
		FS_ADD,
		FS_NORM,
		FS_ROUND,
		FS_DONE
	} fpu_state_t;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_KEYED_MODE = 3'd0;
	localparam logic [2:0] REG_KEY_COUNT  = 3'd1;
	localparam logic [2:0] REG_KEY_ZERO   = 3'd2;
	localparam logic [2:0] REG_KEY_ONE    = 3'd3;
	localparam logic [2:0] REG_KEY_TWO    = 3'd4;
	localparam logic [2:0] REG_KEY_THREE  = 3'd5;

	// number of key registers
	localparam int MAX_KEYS = 4;

	// double constants
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam logic [62:0] INF_MAG     = 63'h7FF0_0000_0000_0000;

endpackage

// ----- hw/rtl/kvsa_fpu.sv -----
// ----------------------------------------------------------------------------
// kvsa_fpu
// Iterative double-precision unit: add, subtract, multiply, divide and
// unsigned 32-bit to double conversion, round to nearest even, one shared
// normalize and round path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kvsa_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  kvsa_pkg::fpu_req_t req,
	output kvsa_pkg::fpu_rsp_t rsp
);
	import kvsa_pkg::*;

	localparam int MUL_STEPS = 53;
	localparam int DIV_STEPS = 56;
	localparam logic signed [13:0] CVT_EXP = 14'sd1054;

	fpu_state_t state_q, state_d;
	fpu_op_t    op_q;

	logic                sign_q;
	logic                sub_q;
	logic signed [13:0]  exp_q;
	logic [57:0]         man_q;
	logic [57:0]         manb_q;
	logic signed [13:0]  expa_q, expb_q;
	logic [52:0]         siga_q, sigb_q;
	logic [105:0]        acc_q;
	logic [55:0]         rem_q, quo_q;
	logic [5:0]          iter_q;
	logic [63:0]         res_q;

	// operand classification
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, sx, a_ge_b;
	logic        spec_hit;
	logic [63:0] spec_val;

	function automatic logic signed [13:0] unp_exp(input logic [63:0] x);
		unp_exp = (x[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, x[62:52]});
	endfunction

	function automatic logic [52:0] unp_sig(input logic [63:0] x);
		unp_sig = {x[62:52] != 11'd0, x[51:0]};
	endfunction

	assign a_nan  = (&req.a[62:52]) && (|req.a[51:0]);
	assign b_nan  = (&req.b[62:52]) && (|req.b[51:0]);
	assign a_inf  = (&req.a[62:52]) && !(|req.a[51:0]);
	assign b_inf  = (&req.b[62:52]) && !(|req.b[51:0]);
	assign a_zero = req.a[62:0] == 63'd0;
	assign b_zero = req.b[62:0] == 63'd0;
	assign sbe    = req.b[63] ^ (req.op == FOP_SUB);
	assign sx     = req.a[63] ^ req.b[63];
	assign a_ge_b = req.a[62:0] >= req.b[62:0];

	// special operands settle the result at once; a nan in the first operand wins
	always_comb begin
		spec_hit = 1'b0;
		spec_val = '0;
		case (req.op)
			FOP_ADD, FOP_SUB: begin
				spec_hit = 1'b1;
				if (a_nan) spec_val = req.a | QUIET_BIT;
				else if (b_nan) spec_val = req.b | QUIET_BIT;
				else if (a_inf && b_inf) spec_val = (req.a[63] == sbe) ? req.a : DEFAULT_NAN;
				else if (a_inf) spec_val = req.a;
				else if (b_inf) spec_val = {sbe, req.b[62:0]};
				else if (a_zero && b_zero) spec_val = {req.a[63] & sbe, 63'd0};
				else if (a_zero) spec_val = {sbe, req.b[62:0]};
				else if (b_zero) spec_val = req.a;
				else spec_hit = 1'b0;
			end
			FOP_MUL: begin
				spec_hit = 1'b1;
				if (a_nan) spec_val = req.a | QUIET_BIT;
				else if (b_nan) spec_val = req.b | QUIET_BIT;
				else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = DEFAULT_NAN;
				else if (a_inf || b_inf) spec_val = {sx, INF_MAG};
				else if (a_zero || b_zero) spec_val = {sx, 63'd0};
				else spec_hit = 1'b0;
			end
			FOP_DIV: begin
				spec_hit = 1'b1;
				if (a_nan) spec_val = req.a | QUIET_BIT;
				else if (b_nan) spec_val = req.b | QUIET_BIT;
				else if ((a_inf && b_inf) || (a_zero && b_zero)) spec_val = DEFAULT_NAN;
				else if (a_inf || b_zero) spec_val = {sx, INF_MAG};
				else if (b_inf || a_zero) spec_val = {sx, 63'd0};
				else spec_hit = 1'b0;
			end
			FOP_CVT: begin
				spec_hit = req.a[31:0] == 32'd0;
			end
			default: ;
		endcase
	end

	// alignment of the smaller addend with sticky collection
	logic signed [13:0] exp_diff;
	logic [5:0]         shamt;
	logic [57:0]        aligned;
	assign exp_diff = expa_q - expb_q;
	assign shamt    = exp_diff[5:0];
	always_comb begin
		if (exp_diff > 14'sd57) begin
			aligned = {57'd0, |manb_q};
		end else begin
			aligned = (manb_q >> shamt) |
				{57'd0, |(manb_q & ~({58{1'b1}} << shamt))};
		end
	end

	// add or subtract of aligned magnitudes
	logic [57:0] sum;
	assign sum = sub_q ? (man_q - manb_q) : (man_q + manb_q);

	// one shift-add step of the multiplier
	logic [105:0] acc_d;
	assign acc_d = {acc_q[104:0], 1'b0} + (sigb_q[52] ? {53'd0, siga_q} : 106'd0);

	// one restoring step of the divider
	logic        div_ge;
	logic [55:0] rem_n, quo_d;
	assign div_ge = rem_q >= {3'b000, sigb_q};
	assign rem_n  = div_ge ? (rem_q - {3'b000, sigb_q}) : rem_q;
	assign quo_d  = {quo_q[54:0], div_ge};

	// normalize decisions, one bit per cycle
	logic norm_right, norm_left, norm_done;
	assign norm_right = (man_q[57:56] != 2'b00) || (exp_q < 14'sd1);
	assign norm_left  = !man_q[55] && (exp_q > 14'sd1);
	assign norm_done  = (man_q == 58'd0) || (!norm_right && !norm_left);

	// round to nearest even
	logic               rnd_up, hid;
	logic [53:0]        mant54;
	logic signed [13:0] exp_r;
	logic [63:0]        rnd_val;
	always_comb begin
		rnd_up = man_q[2] & (man_q[3] | man_q[1] | man_q[0]);
		mant54 = {1'b0, man_q[55:3]} + {53'd0, rnd_up};
		exp_r  = mant54[53] ? (exp_q + 14'sd1) : exp_q;
		hid    = mant54[53] | mant54[52];
		if (hid && (exp_r >= 14'sd2047)) begin
			rnd_val = {sign_q, INF_MAG};
		end else begin
			rnd_val = {sign_q, hid ? exp_r[10:0] : 11'd0,
				mant54[53] ? 52'd0 : mant54[51:0]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (req.start) begin
					if (spec_hit) state_d = FS_DONE;
					else if (req.op == FOP_ADD || req.op == FOP_SUB) state_d = FS_ALIGN;
					else if (req.op == FOP_CVT) state_d = FS_NORM;
					else state_d = FS_PRENORM;
				end
			end
			FS_PRENORM: begin
				if (siga_q[52] && sigb_q[52])
					state_d = (op_q == FOP_MUL) ? FS_MUL : FS_DIV;
			end
			FS_MUL: if (iter_q == 6'(MUL_STEPS - 1)) state_d = FS_NORM;
			FS_DIV: if (iter_q == 6'(DIV_STEPS - 1)) state_d = FS_NORM;
			FS_ALIGN: state_d = FS_ADD;
			FS_ADD: state_d = FS_NORM;
			FS_NORM: if (norm_done) state_d = FS_ROUND;
			FS_ROUND: state_d = FS_DONE;
			FS_DONE: state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.busy = state_q != FS_IDLE;
		rsp.done = state_q == FS_DONE;
		rsp.res  = res_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			FS_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					if (spec_hit) begin
						res_q <= spec_val;
					end else begin
						case (req.op)
							FOP_ADD, FOP_SUB: begin
								sub_q <= req.a[63] ^ sbe;
								if (a_ge_b) begin
									sign_q <= req.a[63];
									expa_q <= unp_exp(req.a);
									man_q  <= {2'b00, unp_sig(req.a), 3'b000};
									expb_q <= unp_exp(req.b);
									manb_q <= {2'b00, unp_sig(req.b), 3'b000};
								end else begin
									sign_q <= sbe;
									expa_q <= unp_exp(req.b);
									man_q  <= {2'b00, unp_sig(req.b), 3'b000};
									expb_q <= unp_exp(req.a);
									manb_q <= {2'b00, unp_sig(req.a), 3'b000};
								end
							end
							FOP_MUL, FOP_DIV: begin
								sign_q <= sx;
								siga_q <= unp_sig(req.a);
								sigb_q <= unp_sig(req.b);
								expa_q <= unp_exp(req.a);
								expb_q <= unp_exp(req.b);
							end
							default: begin
								sign_q <= 1'b0;
								man_q  <= {2'b00, req.a[31:0], 24'd0};
								exp_q  <= CVT_EXP;
							end
						endcase
					end
				end
			end
			FS_PRENORM: begin
				if (!siga_q[52]) begin
					siga_q <= {siga_q[51:0], 1'b0};
					expa_q <= expa_q - 14'sd1;
				end
				if (!sigb_q[52]) begin
					sigb_q <= {sigb_q[51:0], 1'b0};
					expb_q <= expb_q - 14'sd1;
				end
				acc_q  <= '0;
				rem_q  <= {3'b000, siga_q};
				quo_q  <= '0;
				iter_q <= '0;
			end
			FS_MUL: begin
				acc_q  <= acc_d;
				sigb_q <= {sigb_q[51:0], 1'b0};
				iter_q <= iter_q + 6'd1;
				if (iter_q == 6'(MUL_STEPS - 1)) begin
					man_q <= {2'b00, acc_d[105:50]} | {57'd0, |acc_d[49:0]};
					exp_q <= expa_q + expb_q - 14'sd1022;
				end
			end
			FS_DIV: begin
				rem_q  <= {rem_n[54:0], 1'b0};
				quo_q  <= quo_d;
				iter_q <= iter_q + 6'd1;
				if (iter_q == 6'(DIV_STEPS - 1)) begin
					man_q <= {2'b00, quo_d} | {57'd0, rem_n != 56'd0};
					exp_q <= expa_q - expb_q + 14'sd1023;
				end
			end
			FS_ALIGN: manb_q <= aligned;
			FS_ADD: begin
				man_q <= sum;
				exp_q <= expa_q;
				if (sum == 58'd0) sign_q <= 1'b0;
			end
			FS_NORM: begin
				if (!norm_done) begin
					if (norm_right) begin
						if (exp_q < -14'sd60) begin
							man_q <= {57'd0, 1'b1};
							exp_q <= 14'sd1;
						end else begin
							man_q <= {1'b0, man_q[57:2], man_q[1] | man_q[0]};
							exp_q <= exp_q + 14'sd1;
						end
					end else begin
						man_q <= {man_q[56:0], 1'b0};
						exp_q <= exp_q - 14'sd1;
					end
				end
			end
			FS_ROUND: res_q <= rnd_val;
			default: ;
		endcase
	end

	`ASSERT_ALWAYS(a_done_pulse, rsp.done |=> !rsp.done)
	`ASSERT_ALWAYS(a_start_when_idle, req.start |-> !rsp.busy)
	`ASSERT_NEVER(a_round_headroom, (state_q == FS_ROUND) && (man_q[57:56] != 2'b00))
	`ASSERT_NEVER(a_round_low_exp, (state_q == FS_ROUND) && (exp_q < 14'sd1))

endmodule

// ----- hw/rtl/keyed_sample_variance_aggregator.sv -----
// A null or unmatched row does not stall the input. A matching row stalls it for a 53-step
// square, skipped for a zero sample, and two adds whose normalize runs one bit a cycle, all
// in one shared floating-point unit.
// A finish skips floating-point work for a bucket with at most one sample, else it runs two
// 56-step divides, one multiply, one subtract, two conversions; no row is taken meanwhile.
// Asynchronous reset clears config to its reset values and every bucket to zero.
// ----------------------------------------------------------------------------
// keyed_sample_variance_aggregator
// Keyed per-bucket sum, sum of squares and count of double samples, with
// sample variance per bucket on a finish transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_sample_variance_aggregator #(
	parameter int NUM_BUCKETS = 4,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kvsa_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output kvsa_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import kvsa_pkg::*;

	localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int LIM = (NUM_BUCKETS < MAX_KEYS) ? NUM_BUCKETS : MAX_KEYS;
	localparam int CW  = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

	agg_state_t state_q, state_d;
	logic       issued_q;
	logic [BW-1:0] b_q;
	logic [63:0] x_q, t_q, dn_q;
	logic        null_q;

	logic [63:0] ss_q  [NUM_BUCKETS];
	logic [63:0] rs_q  [NUM_BUCKETS];
	logic [31:0] cnt_q [NUM_BUCKETS];

	logic        keyed_q;
	logic [2:0]  kcount_q;
	logic [31:0] key_q [MAX_KEYS];

	logic      out_valid_q;
	out_item_t out_q;

	fpu_req_t fpu_req;
	fpu_rsp_t fpu_rsp;

	kvsa_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	// handshakes
	logic in_acc, out_free, cfg_wr, last_bkt;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_wr   = psel && penable && pwrite;

	// buckets in use
	logic [2:0] nb;
	always_comb begin
		if (!keyed_q || kcount_q == 3'd0) nb = 3'd1;
		else if (kcount_q > 3'(LIM)) nb = 3'(LIM);
		else nb = kcount_q;
	end
	assign last_bkt = (3'(b_q) + 3'd1) == nb;

	// key match, lowest index wins
	logic          hit;
	logic [BW-1:0] hit_idx;
	always_comb begin
		hit     = !keyed_q;
		hit_idx = '0;
		if (keyed_q) begin
			for (int i = LIM - 1; i >= 0; i--) begin
				if ((3'(i) < nb) && (key_q[i][CW-1:0] == in_item.row_key[CW-1:0])) begin
					hit     = 1'b1;
					hit_idx = BW'(i);
				end
			end
		end
	end

	// current bucket
	logic [63:0] ss_cur, rs_cur;
	logic [31:0] cnt_cur;
	assign ss_cur  = ss_q[b_q];
	assign rs_cur  = rs_q[b_q];
	assign cnt_cur = cnt_q[b_q];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_item.mode) state_d = ST_FIN_CHECK;
					else if (!in_item.sample_is_null && hit) state_d = ST_ACC_SQ;
				end
			end
			ST_ACC_SQ: if (fpu_rsp.done) state_d = ST_ACC_SS;
			ST_ACC_SS: if (fpu_rsp.done) state_d = ST_ACC_RS;
			ST_ACC_RS: if (fpu_rsp.done) state_d = ST_IDLE;
			ST_FIN_CHECK: begin
				if (cnt_cur == 32'd0 || cnt_cur == 32'd1) state_d = ST_FIN_EMIT;
				else state_d = ST_FIN_CVT_N;
			end
			ST_FIN_CVT_N: if (fpu_rsp.done) state_d = ST_FIN_PROD;
			ST_FIN_PROD: if (fpu_rsp.done) state_d = ST_FIN_QUOT;
			ST_FIN_QUOT: if (fpu_rsp.done) state_d = ST_FIN_NUM;
			ST_FIN_NUM: if (fpu_rsp.done) state_d = ST_FIN_CVT_M;
			ST_FIN_CVT_M: if (fpu_rsp.done) state_d = ST_FIN_VAR;
			ST_FIN_VAR: if (fpu_rsp.done) state_d = ST_FIN_EMIT;
			ST_FIN_EMIT: begin
				if (out_free) state_d = last_bkt ? ST_IDLE : ST_FIN_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// floating-point requests
	always_comb begin
		fpu_req.start = 1'b0;
		fpu_req.op    = FOP_ADD;
		fpu_req.a     = '0;
		fpu_req.b     = '0;
		case (state_q)
			ST_ACC_SQ: begin
				fpu_req.op = FOP_MUL;
				fpu_req.a  = x_q;
				fpu_req.b  = x_q;
			end
			ST_ACC_SS: begin
				fpu_req.a = ss_cur;
				fpu_req.b = t_q;
			end
			ST_ACC_RS: begin
				fpu_req.a = rs_cur;
				fpu_req.b = x_q;
			end
			ST_FIN_CVT_N: begin
				fpu_req.op = FOP_CVT;
				fpu_req.a  = {32'd0, cnt_cur};
			end
			ST_FIN_PROD: begin
				fpu_req.op = FOP_MUL;
				fpu_req.a  = rs_cur;
				fpu_req.b  = rs_cur;
			end
			ST_FIN_QUOT, ST_FIN_VAR: begin
				fpu_req.op = FOP_DIV;
				fpu_req.a  = t_q;
				fpu_req.b  = dn_q;
			end
			ST_FIN_NUM: begin
				fpu_req.op = FOP_SUB;
				fpu_req.a  = ss_cur;
				fpu_req.b  = t_q;
			end
			ST_FIN_CVT_M: begin
				fpu_req.op = FOP_CVT;
				fpu_req.a  = {32'd0, cnt_cur - 32'd1};
			end
			default: ;
		endcase
		case (state_q)
			ST_ACC_SQ, ST_ACC_SS, ST_ACC_RS, ST_FIN_CVT_N, ST_FIN_PROD,
			ST_FIN_QUOT, ST_FIN_NUM, ST_FIN_CVT_M, ST_FIN_VAR: fpu_req.start = !issued_q;
			default: fpu_req.start = 1'b0;
		endcase
	end

	// port outputs
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign pready    = 1'b1;

	// register readback
	always_comb begin
		case (paddr[4:2])
			REG_KEYED_MODE: prdata = {31'd0, keyed_q};
			REG_KEY_COUNT:  prdata = {29'd0, kcount_q};
			REG_KEY_ZERO:   prdata = key_q[0];
			REG_KEY_ONE:    prdata = key_q[1];
			REG_KEY_TWO:    prdata = key_q[2];
			REG_KEY_THREE:  prdata = key_q[3];
			default:        prdata = 32'd0;
		endcase
	end

	// control, config and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			keyed_q     <= 1'b0;
			kcount_q    <= 3'd1;
			for (int i = 0; i < MAX_KEYS; i++) key_q[i] <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				ss_q[i]  <= '0;
				rs_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (fpu_req.start) issued_q <= 1'b1;
			else if (fpu_rsp.done) issued_q <= 1'b0;

			// config write
			if (cfg_wr) begin
				case (paddr[4:2])
					REG_KEYED_MODE: keyed_q  <= pwdata[0];
					REG_KEY_COUNT:  kcount_q <= pwdata[2:0];
					REG_KEY_ZERO:   key_q[0] <= pwdata;
					REG_KEY_ONE:    key_q[1] <= pwdata;
					REG_KEY_TWO:    key_q[2] <= pwdata;
					REG_KEY_THREE:  key_q[3] <= pwdata;
					default: ;
				endcase
			end

			// bucket updates
			if (state_q == ST_ACC_SS && fpu_rsp.done) ss_q[b_q] <= fpu_rsp.res;
			if (state_q == ST_ACC_RS && fpu_rsp.done) begin
				rs_q[b_q] <= fpu_rsp.res;
				if (cnt_cur != 32'hFFFF_FFFF) cnt_q[b_q] <= cnt_cur + 32'd1;
			end
			if (state_q == ST_FIN_EMIT && out_free && last_bkt) begin
				for (int i = 0; i < NUM_BUCKETS; i++) begin
					ss_q[i]  <= '0;
					rs_q[i]  <= '0;
					cnt_q[i] <= '0;
				end
			end

			// result register
			if (state_q == ST_FIN_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			x_q <= in_item.sample;
			b_q <= in_item.mode ? '0 : hit_idx;
		end
		if (fpu_rsp.done) begin
			case (state_q)
				ST_FIN_CVT_N, ST_FIN_CVT_M: dn_q <= fpu_rsp.res;
				default: t_q <= fpu_rsp.res;
			endcase
		end
		if (state_q == ST_FIN_CHECK) begin
			null_q <= cnt_cur == 32'd0;
			if (cnt_cur == 32'd0 || cnt_cur == 32'd1) t_q <= '0;
		end
		if (state_q == ST_FIN_VAR) null_q <= 1'b0;
		if (state_q == ST_FIN_EMIT && out_free) begin
			out_q.bucket           <= 2'(b_q);
			out_q.variance         <= null_q ? 64'd0 : {1'b0, t_q[62:0]};
			out_q.variance_is_null <= null_q;
			out_q.last             <= last_bkt;
			if (!last_bkt) b_q <= b_q + BW'(1);
		end
	end

	`ASSERT_ALWAYS(a_ready_fpu_idle, !in_stall |-> !fpu_rsp.busy)
	`ASSERT_ALWAYS(a_done_when_issued, fpu_rsp.done |-> issued_q)
	`ASSERT_ALWAYS(a_null_is_zero, (out_valid && out_item.variance_is_null) |-> (out_item.variance == 64'd0))
	`ASSERT_NEVER(a_issue_in_idle, (state_q == ST_IDLE) && issued_q)

endmodule

// ----- tb/tb_keyed_sample_variance_aggregator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_sample_variance_aggregator
// Self-checking bench for the keyed sample variance aggregator. A queue-fed
// driver sends rows in random bursts, a monitor with its own stall pattern
// compares each variance transfer against an in-bench bucket model that is
// run once per accepted row. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_keyed_sample_variance_aggregator;
	import kvsa_pkg::*;

	localparam int NB = 4;
	localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic MODE_ROW    = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	keyed_sample_variance_aggregator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register mirror
	logic        cfg_keyed;
	logic [2:0]  cfg_count;
	logic [31:0] cfg_key [NB];

	// bucket model
	real         acc_sq [NB];
	real         acc_sum [NB];
	int unsigned acc_n [NB];

	in_item_t  pending_rows [$];
	out_item_t expected_variances [$];
	int        errors = 0;
	int        rows_sent = 0;
	int        finishes_sent = 0;
	int        variances_seen = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        cyc = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int active_buckets();
		int n;
		n = cfg_count;
		if (n < 1) n = 1;
		if (n > NB) n = NB;
		return n;
	endfunction

	function automatic logic [63:0] bucket_variance(int b);
		real dn;
		real num;
		real v;
		if (acc_n[b] == 1) return 64'd0;
		dn = real'(acc_n[b]);
		num = acc_sq[b] - acc_sum[b] * acc_sum[b] / dn;
		v = num / real'(acc_n[b] - 1);
		return $realtobits(v) & ABS_MASK;
	endfunction

	// update the bucket model for one accepted row
	task automatic predict_row(in_item_t it);
		int nb;
		int hit;
		real x;
		out_item_t r;
		nb = active_buckets();
		if (it.mode == MODE_ROW) begin
			if (it.sample_is_null) return;
			hit = -1;
			if (!cfg_keyed) hit = 0;
			else begin
				for (int i = nb - 1; i >= 0; i--)
					if (cfg_key[i] == it.row_key) hit = i;
			end
			if (hit < 0) return;
			x = $bitstoreal(it.sample);
			acc_sq[hit] = acc_sq[hit] + x * x;
			acc_sum[hit] = acc_sum[hit] + x;
			if (acc_n[hit] != 32'hFFFF_FFFF) acc_n[hit]++;
		end else begin
			if (!cfg_keyed) nb = 1;
			for (int i = 0; i < nb; i++) begin
				r.bucket = 2'(i);
				r.variance_is_null = (acc_n[i] == 0);
				r.variance = r.variance_is_null ? 64'd0 : bucket_variance(i);
				r.last = (i == nb - 1);
				expected_variances.push_back(r);
			end
			for (int i = 0; i < NB; i++) begin
				acc_sq[i] = 0.0;
				acc_sum[i] = 0.0;
				acc_n[i] = 0;
			end
		end
	endtask

	// driver: bursts and gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			logic taken;
			taken = in_valid && !in_stall;
			if (taken) begin
				predict_row(pending_rows.pop_front());
				rows_sent++;
				if (in_item.mode == MODE_FINISH) finishes_sent++;
			end
			if (!in_valid || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_rows.size() > 0) begin
					in_valid <= 1'b1;
					in_item  <= pending_rows[0];
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern: free, random or long blocks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			case ((cyc / 300) % 3)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 9) < 4);
				end
				default: begin
					out_stall <= ((cyc % 40) < 25);
				end
			endcase
		end
	end

	// monitor: compare each variance transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			out_item_t e;
			logic v_ok;
			variances_seen++;
			if (expected_variances.size() == 0) begin
				$display("%0t: unexpected variance transfer %h", $time, out_item);
				errors++;
			end else begin
				e = expected_variances.pop_front();
				// any nan encoding is accepted where a nan is predicted
				if (e.variance[62:52] == 11'h7FF && e.variance[51:0] != 0)
					v_ok = out_item.variance[62:52] == 11'h7FF && out_item.variance[51:0] != 0;
				else
					v_ok = out_item.variance == e.variance;
				if (out_item.bucket != e.bucket || !v_ok ||
				    out_item.variance_is_null != e.variance_is_null || out_item.last != e.last) begin
					$display("%0t: mismatch expected b=%0d v=%h null=%b last=%b got b=%0d v=%h null=%b last=%b",
						$time, e.bucket, e.variance, e.variance_is_null, e.last,
						out_item.bucket, out_item.variance, out_item.variance_is_null,
						out_item.last);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_KEYED_MODE: cfg_keyed = val[0];
			REG_KEY_COUNT:  cfg_count = val[2:0];
			REG_KEY_ZERO:   cfg_key[0] = val;
			REG_KEY_ONE:    cfg_key[1] = val;
			REG_KEY_TWO:    cfg_key[2] = val;
			default:        cfg_key[3] = val;
		endcase
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_rows.size() != 0 || in_valid || expected_variances.size() != 0);
		// a trailing accumulate row may still be in the adder
		repeat (400) @(posedge clk);
	endtask

	function automatic in_item_t make_row(logic m, logic [63:0] s, logic nl, logic [31:0] k);
		in_item_t it;
		it.mode = m;
		it.sample = s;
		it.sample_is_null = nl;
		it.row_key = k;
		return it;
	endfunction

	function automatic logic [63:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: return $realtobits(real'($urandom) * 1.0e6);
			default: return $realtobits((real'($urandom_range(0, 4000)) - 2000.0) / 8.0);
		endcase
	endfunction

	// random rows: mostly matching keys, some noise and finishes
	task automatic queue_random(int count);
		logic [31:0] k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				pending_rows.push_back(make_row(MODE_FINISH, {$urandom, $urandom},
					1'($urandom_range(0, 1)), $urandom));
			end else begin
				k = ($urandom_range(0, 4) == 0) ? $urandom : cfg_key[$urandom_range(0, NB - 1)];
				pending_rows.push_back(make_row(MODE_ROW, rand_sample(),
					($urandom_range(0, 9) == 0), k));
			end
		end
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
	endtask

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cfg_keyed = 1'b0;
		cfg_count = 3'd1;
		for (int i = 0; i < NB; i++) begin
			cfg_key[i] = '0;
			acc_sq[i] = 0.0;
			acc_sum[i] = 0.0;
			acc_n[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed, unkeyed: empty, single, extremes, specials, nulls
		pending_rows.push_back(make_row(MODE_FINISH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(3.5), 1'b0, 32'h8000_0000));
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(1.0), 1'b0, 32'h7FFF_FFFF));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(-2.0), 1'b0, 32'd5));
		pending_rows.push_back(make_row(MODE_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, 64'd0, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, 64'h7FF0_0000_0000_0000, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(1.0), 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, 64'h7FF8_0000_0000_0001, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, 64'h8000_0000_0000_0000, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_ROW, 64'h0000_0000_0000_0001, 1'b0, 32'd0));
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
		wait_drained();

		// directed, keyed with extreme and duplicate keys
		write_reg(REG_KEYED_MODE, 32'd1);
		write_reg(REG_KEY_COUNT, 32'd4);
		write_reg(REG_KEY_ZERO, 32'h8000_0000);
		write_reg(REG_KEY_ONE, 32'h7FFF_FFFF);
		write_reg(REG_KEY_TWO, 32'h7FFF_FFFF);
		write_reg(REG_KEY_THREE, 32'hFFFF_FFFF);
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(4.0), 1'b0, 32'h8000_0000));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(6.0), 1'b0, 32'h8000_0000));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(9.0), 1'b0, 32'h7FFF_FFFF));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(7.0), 1'b0, 32'h1234_5678));
		pending_rows.push_back(make_row(MODE_ROW, $realtobits(-1.0), 1'b0, 32'hFFFF_FFFF));
		pending_rows.push_back(make_row(MODE_FINISH, 64'd0, 1'b0, 32'd0));
		wait_drained();

		// random phases over several register settings
		queue_random(30);
		wait_drained();
		write_reg(REG_KEY_COUNT, 32'd0);
		queue_random(25);
		wait_drained();
		write_reg(REG_KEY_COUNT, 32'd7);
		write_reg(REG_KEY_ZERO, $urandom);
		write_reg(REG_KEY_ONE, $urandom);
		write_reg(REG_KEY_TWO, 32'd0);
		write_reg(REG_KEY_THREE, 32'd0);
		queue_random(35);
		wait_drained();
		write_reg(REG_KEY_COUNT, 32'd2);
		write_reg(REG_KEY_ZERO, 32'd17);
		write_reg(REG_KEY_ONE, 32'd17);
		queue_random(30);
		wait_drained();
		write_reg(REG_KEY_COUNT, 32'd3);
		write_reg(REG_KEY_TWO, $urandom);
		queue_random(30);
		wait_drained();
		write_reg(REG_KEYED_MODE, 32'd0);
		queue_random(45);
		wait_drained();

		$display("rows sent %0d with %0d finishes, %0d variances checked",
			rows_sent, finishes_sent, variances_seen);
		$display("covered unkeyed and keyed routing, key counts 0..7, duplicate keys, specials");
		if (errors == 0) begin
			$display("keyed_sample_variance_aggregator verification clean");
		end else begin
			$display("keyed_sample_variance_aggregator verification failed");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#(20_000_000);
		$display("keyed_sample_variance_aggregator verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/kvsa_pkg.sv
hw/rtl/kvsa_fpu.sv
hw/rtl/keyed_sample_variance_aggregator.sv
tb/tb_keyed_sample_variance_aggregator.sv
